// File: rtl/spt_pkg.sv
// Shared types and constants of the sorted priority table.
// No dependencies; used by spt_cell and sorted_priority_table_unit.
package spt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int MAX_REPORT  = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int OP_W     = 2;
   localparam int HANDLE_W = 16;
   localparam int PRIO_W   = 8;
   localparam int BIRTH_W  = 16;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // Cell commands
   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_HOLD      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_NEW  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TAKE_PREV = 2'd2;
   localparam logic [CMD_W-1:0] CMD_TAKE_NEXT = 2'd3;

   typedef struct packed {
      logic                used;
      logic [HANDLE_W-1:0] handle;
      logic [PRIO_W-1:0]   priority_val;
      logic [BIRTH_W-1:0]  birth;
   } slot_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                occupied;
      logic [SLOT_W-1:0]   slot;
      logic [HANDLE_W-1:0] handle;
      logic [PRIO_W-1:0]   priority_val;
      logic [BIRTH_W-1:0]  birth;
      logic                last;
   } rsp_type;

endpackage

// File: rtl/spt_cell.sv
// One slot of the sorted table: holds an entry and loads it from the new
// entry or from either neighbor. Depends on spt_pkg.
module spt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [spt_pkg::CMD_W-1:0] cmd,
   input  spt_pkg::slot_type       new_entry,
   input  spt_pkg::slot_type       prev_entry,
   input  spt_pkg::slot_type       next_entry,
   output spt_pkg::slot_type       entry,
   output logic                    stop
);

   logic                         used_ff, used_in;
   logic [spt_pkg::HANDLE_W-1:0] handle_ff, handle_in;
   logic [spt_pkg::PRIO_W-1:0]   prio_ff, prio_in;
   logic [spt_pkg::BIRTH_W-1:0]  birth_ff, birth_in;
   spt_pkg::slot_type            src;
   logic                         beats;

   // new entry goes ahead of this one on higher priority, then on earlier birth
   assign beats = (new_entry.priority_val != prio_ff) ?
                  (new_entry.priority_val > prio_ff) : (new_entry.birth < birth_ff);
   assign stop  = !used_ff || beats;

   always_comb begin
      case (cmd)
         spt_pkg::CMD_LOAD_NEW:  src = new_entry;
         spt_pkg::CMD_TAKE_PREV: src = prev_entry;
         spt_pkg::CMD_TAKE_NEXT: src = next_entry;
         default:                src = entry;
      endcase
      used_in   = src.used;
      handle_in = src.handle;
      prio_in   = src.priority_val;
      birth_in  = src.birth;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      prio_ff   <= prio_in;
      birth_ff  <= birth_in;
   end

   assign entry.used         = used_ff;
   assign entry.handle       = handle_ff;
   assign entry.priority_val = prio_ff;
   assign entry.birth        = birth_ff;

endmodule

// File: rtl/sorted_priority_table_unit.sv
// Sorted priority table: a row of TABLE_DEPTH slot cells kept in priority
// order (higher priority first, then earlier birth, ties in arrival order),
// with empty slots at the end. Insert and remove take effect in the cycle the
// request transfers: on insert every cell compares the new key at once, and
// the row shifts by one place. The report that follows rotates the whole row
// through cell 0 one place per cycle while the result side takes the results;
// an insert or remove that leaves the table empty gives a single unoccupied
// result instead. Read, a failed request and the out-of-range case give one
// result. A new request is taken once the previous one has moved all its
// results into the output register. Depends on spt_pkg and spt_cell.
module sorted_priority_table_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [spt_pkg::OP_W-1:0]         req_op,
   input  logic [spt_pkg::HANDLE_W-1:0]     req_handle,
   input  logic [spt_pkg::PRIO_W-1:0]       req_priority_req,
   input  logic [spt_pkg::BIRTH_W-1:0]      req_birth_time,
   input  logic [spt_pkg::POS_W-1:0]        req_position,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [spt_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_occupied,
   output logic [spt_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [spt_pkg::HANDLE_W-1:0]     rsp_entry_handle,
   output logic [spt_pkg::PRIO_W-1:0]       rsp_entry_priority,
   output logic [spt_pkg::BIRTH_W-1:0]      rsp_entry_birth,
   output logic                             rsp_last
);

   localparam int DEPTH = spt_pkg::TABLE_DEPTH;
   localparam int CNT_W = spt_pkg::CNT_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ONE  = 2'd1;
   localparam logic [1:0] S_RPT  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] rot_ff, rot_in;
   logic [CNT_W-1:0] count_ff, count_in;
   spt_pkg::rsp_type pend_ff, pend_in;
   spt_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   spt_pkg::slot_type          cell_q    [DEPTH];
   spt_pkg::slot_type          prev_bus  [DEPTH];
   spt_pkg::slot_type          next_bus  [DEPTH];
   logic [spt_pkg::CMD_W-1:0]  cmd       [DEPTH];
   logic [DEPTH-1:0]           stop_vec;
   logic [DEPTH-1:0]           used_vec;

   spt_pkg::slot_type new_entry;
   spt_pkg::slot_type sel_entry;
   spt_pkg::slot_type empty_entry;
   logic              accept, out_free, in_range, full, emit, last_rpt, lap_end;

   assign empty_entry = '0;

   assign new_entry.used         = 1'b1;
   assign new_entry.handle       = req_handle;
   assign new_entry.priority_val = req_priority_req;
   assign new_entry.birth        = req_birth_time;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_range  = (32'(req_position) < DEPTH);
   assign full      = cell_q[DEPTH-1].used;
   assign sel_entry = cell_q[req_position[spt_pkg::IDX_W-1:0]];

   assign emit     = (32'(rot_ff) < 32'(count_ff)) && (32'(rot_ff) < spt_pkg::MAX_REPORT);
   assign last_rpt = (32'(rot_ff) + 1 == 32'(count_ff)) ||
                     (32'(rot_ff) + 1 == spt_pkg::MAX_REPORT);
   assign lap_end  = (rot_ff == CNT_W'(DEPTH - 1));

   // ring during the report; the tail takes an empty slot on remove
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         prev_bus[i] = (i == 0) ? empty_entry : cell_q[(i == 0) ? 0 : i - 1];
         next_bus[i] = (i == DEPTH - 1) ? ((state_ff == S_RPT) ? cell_q[0] : empty_entry)
                                        : cell_q[(i == DEPTH - 1) ? 0 : i + 1];
         used_vec[i] = cell_q[i].used;
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      spt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd[g]),
         .new_entry  (new_entry),
         .prev_entry (prev_bus[g]),
         .next_entry (next_bus[g]),
         .entry      (cell_q[g]),
         .stop       (stop_vec[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      rot_in       = rot_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      for (int i = 0; i < DEPTH; i++) begin
         cmd[i] = spt_pkg::CMD_HOLD;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_in      = '0;
               pend_in.last = 1'b1;
               case (req_op)
                  spt_pkg::OP_INSERT: begin
                     if (full) begin
                        pend_in.status = spt_pkg::ST_FULL;
                        state_in       = S_ONE;
                     end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                           if (i > 0 && stop_vec[(i == 0) ? 0 : i - 1]) begin
                              cmd[i] = spt_pkg::CMD_TAKE_PREV;
                           end else if (stop_vec[i]) begin
                              cmd[i] = spt_pkg::CMD_LOAD_NEW;
                           end
                        end
                        count_in = count_ff + 1'b1;
                        rot_in   = '0;
                        state_in = S_RPT;
                     end
                  end
                  spt_pkg::OP_REMOVE: begin
                     pend_in.slot = req_position[spt_pkg::SLOT_W-1:0];
                     if (!in_range) begin
                        pend_in.status = spt_pkg::ST_RANGE;
                        state_in       = S_ONE;
                     end else if (!sel_entry.used) begin
                        pend_in.status = spt_pkg::ST_EMPTY;
                        state_in       = S_ONE;
                     end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                           if (32'(i) >= 32'(req_position)) begin
                              cmd[i] = spt_pkg::CMD_TAKE_NEXT;
                           end
                        end
                        count_in = count_ff - 1'b1;
                        rot_in   = '0;
                        state_in = S_RPT;
                     end
                  end
                  spt_pkg::OP_READ: begin
                     pend_in.slot = req_position[spt_pkg::SLOT_W-1:0];
                     if (!in_range) begin
                        pend_in.status = spt_pkg::ST_RANGE;
                     end else if (sel_entry.used) begin
                        pend_in.occupied     = 1'b1;
                        pend_in.handle       = sel_entry.handle;
                        pend_in.priority_val = sel_entry.priority_val;
                        pend_in.birth        = sel_entry.birth;
                     end
                     state_in = S_ONE;
                  end
                  default: begin
                     // unused op: drop
                  end
               endcase
            end
         end
         S_ONE: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RPT: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  rsp_in       = '0;
                  rsp_in.last  = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (!emit || out_free) begin
               if (emit) begin
                  rsp_in.status       = spt_pkg::ST_OK;
                  rsp_in.occupied     = 1'b1;
                  rsp_in.slot         = spt_pkg::SLOT_W'(rot_ff);
                  rsp_in.handle       = cell_q[0].handle;
                  rsp_in.priority_val = cell_q[0].priority_val;
                  rsp_in.birth        = cell_q[0].birth;
                  rsp_in.last         = last_rpt;
                  rsp_valid_in        = 1'b1;
               end
               // advance the ring one place
               for (int i = 0; i < DEPTH; i++) begin
                  cmd[i] = spt_pkg::CMD_TAKE_NEXT;
               end
               rot_in = rot_ff + 1'b1;
               if (lap_end) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rot_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_occupied       = rsp_ff.occupied;
   assign rsp_slot           = rsp_ff.slot;
   assign rsp_entry_handle   = rsp_ff.handle;
   assign rsp_entry_priority = rsp_ff.priority_val;
   assign rsp_entry_birth    = rsp_ff.birth;
   assign rsp_last           = rsp_ff.last;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("entry count exceeds table depth");

   a_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((used_vec & (used_vec + 1'b1)) == '0))
      else $error("occupied slots do not form a prefix");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(used_vec) == 32'(count_ff)))
      else $error("entry count disagrees with occupied slots");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == spt_pkg::OP_INSERT && !full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not add an entry");

   a_occ_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.occupied) |-> (rsp_ff.status == spt_pkg::ST_OK))
      else $error("occupied result with error status");
`endif

endmodule

// File: dv/sorted_priority_table_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_priority_table_unit: directed, full-table, backpressure and random
// insert/remove/read traffic, each result checked against a sorted-table predictor.
// Depends on spt_pkg and the sorted_priority_table_unit RTL.
module sorted_priority_table_unit_tb;
   import spt_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 330;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_SHOWN     = 10;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_op;
   logic [HANDLE_W-1:0] req_handle;
   logic [PRIO_W-1:0]   req_priority_req;
   logic [BIRTH_W-1:0]  req_birth_time;
   logic [POS_W-1:0]    req_position;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_occupied;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [HANDLE_W-1:0] rsp_entry_handle;
   logic [PRIO_W-1:0]   rsp_entry_priority;
   logic [BIRTH_W-1:0]  rsp_entry_birth;
   logic                rsp_last;

   slot_type slots_model [TABLE_DEPTH];
   rsp_type  expected_reports [$];

   int error_count   = 0;
   int checked_count = 0;
   int idle_cycles   = 0;
   int n_insert  = 0;
   int n_remove  = 0;
   int n_read    = 0;
   int n_ignored = 0;
   int n_full    = 0;
   int n_range   = 0;
   int n_vacant  = 0;

   bit src_gaps_en   = 1'b0;
   bit sink_stall_en = 1'b0;
   bit sink_hold_req = 1'b0;
   bit sink_holding  = 1'b0;

   sorted_priority_table_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_handle         (req_handle),
      .req_priority_req   (req_priority_req),
      .req_birth_time     (req_birth_time),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_occupied       (rsp_occupied),
      .rsp_slot           (rsp_slot),
      .rsp_entry_handle   (rsp_entry_handle),
      .rsp_entry_priority (rsp_entry_priority),
      .rsp_entry_birth    (rsp_entry_birth),
      .rsp_last           (rsp_last)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------- predictor

   // Entry fields read as zero unless the slot holds an entry.
   function automatic rsp_type make_report(logic [STATUS_W-1:0] status,
                                           logic [SLOT_W-1:0] slot, slot_type e,
                                           logic last);
      rsp_type r;
      r.status       = status;
      r.occupied     = e.used;
      r.slot         = slot;
      r.handle       = e.used ? e.handle : '0;
      r.priority_val = e.used ? e.priority_val : '0;
      r.birth        = e.used ? e.birth : '0;
      r.last         = last;
      return r;
   endfunction

   function automatic bit goes_before(logic [PRIO_W-1:0] prio, logic [BIRTH_W-1:0] birth,
                                      slot_type e);
      if (prio != e.priority_val)
         return prio > e.priority_val;
      return birth < e.birth;
   endfunction

   function automatic int table_count();
      int cnt;
      cnt = 0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (slots_model[i].used) cnt++;
      return cnt;
   endfunction

   // Queue one report per occupied slot in order; an empty table gives a single
   // unoccupied report.
   function automatic void report_table();
      int total;
      int n;
      total = table_count();
      if (total > MAX_REPORT) total = MAX_REPORT;
      if (total == 0) begin
         expected_reports.push_back(make_report(ST_OK, '0, '0, 1'b1));
         return;
      end
      n = 0;
      for (int i = 0; i < TABLE_DEPTH && n < total; i++) begin
         if (slots_model[i].used) begin
            expected_reports.push_back(make_report(ST_OK, SLOT_W'(i), slots_model[i],
                                                   n == total - 1));
            n++;
         end
      end
   endfunction

   function automatic void apply_table_op(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                                          logic [PRIO_W-1:0] prio,
                                          logic [BIRTH_W-1:0] birth,
                                          logic [POS_W-1:0] pos);
      int k;
      slot_type fresh;
      case (op)
         OP_INSERT: begin
            n_insert++;
            if (slots_model[TABLE_DEPTH-1].used) begin
               n_full++;
               expected_reports.push_back(make_report(ST_FULL, '0, '0, 1'b1));
            end else begin
               // equal keys stay ahead of the new entry
               k = 0;
               while (k < TABLE_DEPTH && slots_model[k].used &&
                      !goes_before(prio, birth, slots_model[k]))
                  k++;
               for (int i = TABLE_DEPTH - 1; i > k; i--)
                  slots_model[i] = slots_model[i-1];
               fresh.used         = 1'b1;
               fresh.handle       = handle;
               fresh.priority_val = prio;
               fresh.birth        = birth;
               slots_model[k]     = fresh;
               report_table();
            end
         end
         OP_UNUSED: begin
            n_ignored++;
         end
         default: begin
            if (op == OP_READ) n_read++;
            else n_remove++;
            if (pos >= TABLE_DEPTH) begin
               n_range++;
               expected_reports.push_back(make_report(ST_RANGE, pos[SLOT_W-1:0], '0, 1'b1));
            end else if (op == OP_READ) begin
               expected_reports.push_back(make_report(ST_OK, pos[SLOT_W-1:0],
                                                      slots_model[pos], 1'b1));
            end else if (!slots_model[pos].used) begin
               n_vacant++;
               expected_reports.push_back(make_report(ST_EMPTY, pos[SLOT_W-1:0], '0, 1'b1));
            end else begin
               // close up the gap behind the removed entry
               for (int i = pos; i < TABLE_DEPTH - 1; i++)
                  slots_model[i] = slots_model[i+1];
               slots_model[TABLE_DEPTH-1].used = 1'b0;
               report_table();
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- random helpers

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Narrow ranges half the time for priority and four times in ten for birth so that ties are common.
   function automatic logic [PRIO_W-1:0] pick_priority();
      if ($urandom_range(0, 1) == 0)
         return PRIO_W'($urandom_range(0, 3));
      return PRIO_W'($urandom);
   endfunction

   function automatic logic [BIRTH_W-1:0] pick_birth();
      if ($urandom_range(0, 9) < 4)
         return BIRTH_W'($urandom_range(0, 3));
      return BIRTH_W'($urandom);
   endfunction

   // Mostly occupied slots, some vacant ones and some beyond the table.
   function automatic logic [POS_W-1:0] pick_position();
      int cnt;
      int r;
      cnt = table_count();
      r   = $urandom_range(0, 99);
      if (cnt > 0 && r < 70)
         return POS_W'($urandom_range(0, cnt - 1));
      if (r < 85)
         return POS_W'($urandom_range((cnt < TABLE_DEPTH) ? cnt : 0, TABLE_DEPTH - 1));
      return POS_W'($urandom_range(TABLE_DEPTH, 31));
   endfunction

   // ---------------------------------------------------------------- request side

   task automatic send_request(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle,
                               input logic [PRIO_W-1:0] prio,
                               input logic [BIRTH_W-1:0] birth,
                               input logic [POS_W-1:0] pos);
      int gap;
      gap = src_gaps_en ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_handle       <= handle;
      req_priority_req <= prio;
      req_birth_time   <= birth;
      req_position     <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_table_op(op, handle, prio, birth, pos);
   endtask

   // ---------------------------------------------------------------- result side

   initial begin : result_sink
      int run_len;
      int gap_len;
      int held;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (sink_hold_req) begin
            rsp_ready    <= 1'b0;
            sink_holding  = 1'b1;
            held          = 0;
            while (held < HOLD_CYCLES) begin
               @(negedge clock);
               held++;
            end
            sink_holding  = 1'b0;
            sink_hold_req = 1'b0;
         end else if (!sink_stall_en) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 6);
            gap_len = pick_gap();
            rsp_ready <= 1'b1;
            repeat (run_len) @(negedge clock);
            if (gap_len > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap_len) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      bit      bad;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status       = rsp_status;
         got.occupied     = rsp_occupied;
         got.slot         = rsp_slot;
         got.handle       = rsp_entry_handle;
         got.priority_val = rsp_entry_priority;
         got.birth        = rsp_entry_birth;
         got.last         = rsp_last;
         if (expected_reports.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
               $display("%0t: result with nothing expected: st=%0d slot=%0d h=%h",
                        $realtime, got.status, got.slot, got.handle);
         end else begin
            want = expected_reports.pop_front();
            checked_count++;
            bad = (got.status !== want.status) || (got.occupied !== want.occupied) ||
                  (got.slot !== want.slot) || (got.handle !== want.handle) ||
                  (got.priority_val !== want.priority_val) ||
                  (got.birth !== want.birth) || (got.last !== want.last);
            if (bad) begin
               error_count++;
               if (error_count <= MAX_SHOWN) begin
                  $display("%0t: mismatch exp st=%0d occ=%0d slot=%0d h=%h p=%h b=%h last=%0d",
                           $realtime, want.status, want.occupied, want.slot, want.handle,
                           want.priority_val, want.birth, want.last);
                  $display("%0t:          got st=%0d occ=%0d slot=%0d h=%h p=%h b=%h last=%0d",
                           $realtime, got.status, got.occupied, got.slot, got.handle,
                           got.priority_val, got.birth, got.last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, expected_reports.size());
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      src_gaps_en   = 1'b0;
      sink_stall_en = 1'b0;
      send_request(OP_READ,   '0, '0, '0, 5'd0);     // read of an empty table
      send_request(OP_REMOVE, '0, '0, '0, 5'd0);     // remove from a vacant slot
      send_request(OP_READ,   '0, '0, '0, 5'd16);    // first position past the table
      send_request(OP_READ,   '0, '0, '0, 5'd31);
      send_request(OP_REMOVE, '0, '0, '0, 5'd31);
      send_request(OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 5'd31);
      send_request(OP_INSERT, 16'hFFFF, 8'h00, 16'hFFFF, 5'd0);
      send_request(OP_INSERT, 16'h0000, 8'hFF, 16'h0000, 5'd0);
      send_request(OP_INSERT, 16'h0001, 8'h80, 16'd100, 5'd0);
      send_request(OP_INSERT, 16'h0002, 8'h80, 16'd50, 5'd0);  // earlier birth wins
      send_request(OP_INSERT, 16'h0003, 8'h80, 16'd100, 5'd0); // equal key goes behind
      send_request(OP_INSERT, 16'h0004, 8'h00, 16'h0000, 5'd0);
      send_request(OP_READ,   '0, '0, '0, 5'd0);
      send_request(OP_READ,   '0, '0, '0, 5'd5);
      send_request(OP_READ,   '0, '0, '0, 5'd6);
      send_request(OP_READ,   '0, '0, '0, 5'd15);
      send_request(OP_REMOVE, '0, '0, '0, 5'd2);
      send_request(OP_REMOVE, '0, '0, '0, 5'd0);
      send_request(OP_REMOVE, '0, '0, '0, 5'd3);
      send_request(OP_UNUSED, '0, '0, '0, 5'd0);
      // drain; the final remove leaves the table empty
      send_request(OP_REMOVE, '0, '0, '0, 5'd0);
      send_request(OP_REMOVE, '0, '0, '0, 5'd0);
      send_request(OP_REMOVE, '0, '0, '0, 5'd0);
   endtask

   task automatic test_full_table();
      src_gaps_en   = 1'b0;
      sink_stall_en = 1'b1;
      while (table_count() < TABLE_DEPTH)
         send_request(OP_INSERT, HANDLE_W'($urandom), pick_priority(), pick_birth(), '0);
      send_request(OP_INSERT, HANDLE_W'($urandom), pick_priority(), pick_birth(), '0);
      send_request(OP_INSERT, 16'hFFFF, 8'hFF, 16'h0000, '0);
      send_request(OP_READ,   '0, '0, '0, 5'd15);
      send_request(OP_REMOVE, '0, '0, '0, 5'd15);
      send_request(OP_INSERT, HANDLE_W'($urandom), pick_priority(), pick_birth(), '0);
      send_request(OP_INSERT, HANDLE_W'($urandom), pick_priority(), pick_birth(), '0);
      while (table_count() > 0)
         send_request(OP_REMOVE, '0, '0, '0, POS_W'($urandom_range(0, table_count() - 1)));
   endtask

   // Hold the result side off long enough that the block fills and stalls requests.
   task automatic test_backpressure();
      src_gaps_en   = 1'b0;
      // drop the last request so it is not transferred again while the sink winds down
      @(negedge clock);
      req_valid     <= 1'b0;
      sink_hold_req = 1'b1;
      wait (sink_holding);
      for (int n = 0; n < 24; n++) begin
         if ($urandom_range(0, 3) == 0)
            send_request(OP_READ, '0, '0, '0, pick_position());
         else
            send_request(OP_INSERT, HANDLE_W'($urandom), pick_priority(), pick_birth(), '0);
      end
   endtask

   task automatic test_random();
      int done;
      int seen;
      int r;
      int cnt;
      bit grow;
      logic [OP_W-1:0] op;
      done = 0;
      seen = 0;
      grow = 1'b1;
      while (done < RANDOM_ITEMS) begin
         // switch idling on and off so that some stretches run at full rate
         if (seen % 40 == 0) begin
            src_gaps_en   = $urandom_range(0, 3) != 0;
            sink_stall_en = $urandom_range(0, 3) != 0;
         end
         seen++;
         cnt = table_count();
         if (cnt == 0) grow = 1'b1;
         else if (cnt == TABLE_DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
         else if ($urandom_range(0, 49) == 0) grow = !grow;
         r = $urandom_range(0, 99);
         if (r < 3) op = OP_UNUSED;
         else if (r < 22) op = OP_READ;
         else if (r < (grow ? 77 : 42)) op = OP_INSERT;
         else op = OP_REMOVE;
         send_request(op, HANDLE_W'($urandom), pick_priority(), pick_birth(), pick_position());
         if (op != OP_UNUSED) done++;
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_INSERT;
      req_handle       = '0;
      req_priority_req = '0;
      req_birth_time   = '0;
      req_position     = '0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         slots_model[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_table();
      test_backpressure();
      test_random();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d inserts (%0d refused on a full table), %0d removes, %0d reads,",
               n_insert, n_full, n_remove, n_read);
      $display("%0d unused codes, %0d out-of-range and %0d vacant-slot requests; %0d results",
               n_ignored, n_range, n_vacant, checked_count);
      if (error_count == 0 && expected_reports.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
